// ===== rtl/mfmtfg_pkg.sv =====
// Shared types, constants, the interleave lookup and the CRC function for the MFM track format generator.
package mfmtfg_pkg;

    localparam int unsigned TABLE_BYTES  = 128;
    localparam int unsigned MARK_SLOTS_D = 64;
    localparam int unsigned ILV_LEN_D    = 18;
    localparam int unsigned ILV_ENTRIES  = 18;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 14;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 48;

    localparam logic [7:0] B_GAP   = 8'h4e;
    localparam logic [7:0] B_ZERO  = 8'h00;
    localparam logic [7:0] B_IAM   = 8'hc2;
    localparam logic [7:0] B_IDXAM = 8'hfc;
    localparam logic [7:0] B_SYNC  = 8'ha1;
    localparam logic [7:0] B_IDAM  = 8'hfe;
    localparam logic [7:0] B_DAM   = 8'hfb;
    localparam logic [7:0] B_FILL  = 8'he5;

    localparam logic [14:0] LEN_MIN    = 15'd130;
    localparam logic [14:0] LEN_MAX    = 15'd10560;
    localparam logic [6:0]  SPT_MAX    = 7'd64;
    localparam logic [15:0] SECTOR_PAD = 16'd82;

    typedef enum logic [2:0] {
        CFG_SPT    = 3'd0,
        CFG_FIRST  = 3'd1,
        CFG_SIZE   = 3'd2,
        CFG_ILV    = 3'd3,
        CFG_TBYTES = 3'd4,
        CFG_DD     = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_BYTE     = 2'd0,
        ST_STARTED  = 2'd1,
        ST_REJECTED = 2'd2,
        ST_IDLE     = 2'd3
    } t_status;

    typedef struct packed {
        logic       is_start;
        logic [7:0] cylinder;
        logic       head_number;
    } t_req;

    function automatic logic [4:0] ilv_lookup(input logic mode, input logic [4:0] idx);
        logic [4:0] two;
        logic [4:0] three;
        begin
            case (idx)
                5'd0:  begin two = 5'd0;  three = 5'd0;  end
                5'd1:  begin two = 5'd9;  three = 5'd6;  end
                5'd2:  begin two = 5'd1;  three = 5'd12; end
                5'd3:  begin two = 5'd10; three = 5'd1;  end
                5'd4:  begin two = 5'd2;  three = 5'd7;  end
                5'd5:  begin two = 5'd11; three = 5'd13; end
                5'd6:  begin two = 5'd3;  three = 5'd2;  end
                5'd7:  begin two = 5'd12; three = 5'd8;  end
                5'd8:  begin two = 5'd4;  three = 5'd14; end
                5'd9:  begin two = 5'd13; three = 5'd3;  end
                5'd10: begin two = 5'd5;  three = 5'd9;  end
                5'd11: begin two = 5'd14; three = 5'd15; end
                5'd12: begin two = 5'd6;  three = 5'd4;  end
                5'd13: begin two = 5'd15; three = 5'd10; end
                5'd14: begin two = 5'd7;  three = 5'd16; end
                5'd15: begin two = 5'd16; three = 5'd5;  end
                5'd16: begin two = 5'd8;  three = 5'd11; end
                5'd17: begin two = 5'd17; three = 5'd17; end
                default: begin two = idx; three = idx; end
            endcase
            return mode ? three : two;
        end
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] v);
        logic [15:0] c;
        begin
            c = crc_in ^ {v, 8'h00};
            for (int i = 0; i < 8; i++) begin
                c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
            end
            return c;
        end
    endfunction

endpackage

// ===== rtl/mfmtfg_front.sv =====
// Request intake: accepts items, classifies them and queues them for the engine.
module mfmtfg_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [15:0]          i_s_axis_tdata,   // cylinder[7:0], head_number[8], zero
    input  logic                 i_s_axis_tuser,   // req_type
    output logic                 o_req_valid,
    input  logic                 i_req_ready,
    output mfmtfg_pkg::t_req     o_req
);
    import mfmtfg_pkg::*;

    t_req       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic push;
    logic pop;

    assign o_s_axis_tready = (r_count != 2'd2);
    assign o_req_valid     = (r_count != 2'd0);
    assign o_req           = r_q[r_rd_ptr];
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign pop             = o_req_valid && i_req_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= '{is_start:    ~i_s_axis_tuser,
                               cylinder:    i_s_axis_tdata[7:0],
                               head_number: i_s_axis_tdata[8]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/mfmtfg_engine.sv =====
// Track layout engine: configuration, phase sequencer, CRC and result register.
module mfmtfg_engine #(
    parameter int unsigned MARK_SLOTS     = mfmtfg_pkg::MARK_SLOTS_D,
    parameter int unsigned INTERLEAVE_LEN = mfmtfg_pkg::ILV_LEN_D
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mfmtfg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mfmtfg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                                i_req_valid,
    output logic                                o_req_ready,
    input  mfmtfg_pkg::t_req                    i_req,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [mfmtfg_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    output logic                                o_m_axis_tlast
);
    import mfmtfg_pkg::*;

    typedef enum logic [4:0] {
        PH_GAP0      = 5'd0,
        PH_SYNC0     = 5'd1,
        PH_IAM       = 5'd2,
        PH_IDXAM     = 5'd3,
        PH_GAP1      = 5'd4,
        PH_ID_SYNC   = 5'd6,
        PH_ID_A1     = 5'd7,
        PH_ID_AM     = 5'd8,
        PH_CYL       = 5'd9,
        PH_HEAD      = 5'd10,
        PH_SEC       = 5'd11,
        PH_SIZE      = 5'd12,
        PH_ID_CRC    = 5'd13,
        PH_GAP2      = 5'd14,
        PH_DATA_SYNC = 5'd15,
        PH_DATA_A1   = 5'd16,
        PH_DAM       = 5'd17,
        PH_DATA      = 5'd18,
        PH_DATA_CRC  = 5'd19,
        PH_GAP3      = 5'd20,
        PH_FILL      = 5'd21
    } t_phase;

    logic [6:0]  r_spt;
    logic [7:0]  r_first;
    logic [1:0]  r_size;
    logic        r_ilv;
    logic [13:0] r_tbytes;
    logic        r_dd;

    logic        r_busy;
    t_phase      r_phase;
    logic [10:0] r_cnt;
    logic [13:0] r_off;
    logic [6:0]  r_sidx;
    logic [15:0] r_crc;
    logic [7:0]  r_cyl;
    logic        r_head;
    logic [6:0]  r_marks;

    logic        r_m_valid;
    t_status     r_status;
    logic [7:0]  r_data;
    logic [13:0] r_offset;
    logic        r_flag;
    logic [5:0]  r_slot;
    logic [15:0] r_entry;
    logic        r_last;

    logic        n_busy;
    t_phase      n_phase;
    logic [10:0] n_cnt;
    logic [13:0] n_off;
    logic [6:0]  n_sidx;
    logic [15:0] n_crc;
    logic [7:0]  n_cyl;
    logic        n_head;
    logic [6:0]  n_marks;
    t_status     n_status;
    logic [7:0]  n_data;
    logic [13:0] n_offset;
    logic        n_flag;
    logic [5:0]  n_slot;
    logic [15:0] n_entry;
    logic        n_last;

    logic        fire;
    logic [14:0] w_len;
    logic [10:0] w_sec_len;
    logic [10:0] w_ph_len;
    logic [11:0] w_cnt_inc;
    logic [14:0] w_next_off;
    logic [6:0]  w_sidx_adv;
    logic        w_fits;
    t_phase      w_choose;
    logic [7:0]  w_sec_id;
    logic [4:0]  w_ilv;
    logic [7:0]  w_byte;
    logic        w_crc_in;
    logic [15:0] w_crc_base;

    assign fire        = i_req_valid && (!r_m_valid || i_m_axis_tready);
    assign o_req_ready = !r_m_valid || i_m_axis_tready;

    assign w_len      = 15'(r_tbytes) + 15'(r_tbytes[0]);
    assign w_sec_len  = 11'd128 << r_size;
    assign w_cnt_inc  = 12'(r_cnt) + 12'd1;
    assign w_next_off = 15'(r_off) + 15'd1;
    assign w_sidx_adv = (r_phase == PH_GAP3) ? (r_sidx + 7'd1) : r_sidx;
    assign w_fits     = (w_sidx_adv < r_spt) && (r_marks < 7'(MARK_SLOTS)) &&
                        ((16'(w_next_off) + 16'(w_sec_len) + SECTOR_PAD) < 16'(w_len));
    assign w_choose   = w_fits ? PH_ID_SYNC : PH_FILL;
    assign w_ilv      = ilv_lookup(r_ilv, r_sidx[4:0]);
    assign w_sec_id   = (((32'(r_sidx) < INTERLEAVE_LEN) && (32'(r_sidx) < ILV_ENTRIES))
                         ? 8'(w_ilv) : 8'(r_sidx)) + r_first;

    always_comb begin
        case (r_phase)
            PH_GAP0:                   w_ph_len = 11'd54;
            PH_SYNC0:                  w_ph_len = 11'd9;
            PH_IAM:                    w_ph_len = 11'd3;
            PH_GAP1:                   w_ph_len = 11'd32;
            PH_ID_SYNC:                w_ph_len = 11'd8;
            PH_ID_A1, PH_DATA_A1:      w_ph_len = 11'd3;
            PH_ID_CRC, PH_DATA_CRC:    w_ph_len = 11'd2;
            PH_GAP2:                   w_ph_len = 11'd22;
            PH_DATA_SYNC:              w_ph_len = 11'd12;
            PH_DATA:                   w_ph_len = w_sec_len;
            PH_GAP3:                   w_ph_len = 11'd24;
            default:                   w_ph_len = 11'd1;
        endcase
    end

    always_comb begin
        w_byte     = B_GAP;
        w_crc_in   = 1'b0;
        w_crc_base = r_crc;
        case (r_phase)
            PH_SYNC0, PH_ID_SYNC, PH_DATA_SYNC: w_byte = B_ZERO;
            PH_IAM:   w_byte = B_IAM;
            PH_IDXAM: w_byte = B_IDXAM;
            PH_ID_A1, PH_DATA_A1: begin
                if (r_cnt == 11'd0) begin
                    w_crc_base = 16'hffff;
                end
                w_byte   = B_SYNC;
                w_crc_in = 1'b1;
            end
            PH_ID_AM: begin w_byte = B_IDAM;  w_crc_in = 1'b1; end
            PH_CYL:   begin w_byte = r_cyl;   w_crc_in = 1'b1; end
            PH_HEAD:  begin w_byte = {7'd0, r_head}; w_crc_in = 1'b1; end
            PH_SEC:   begin w_byte = w_sec_id; w_crc_in = 1'b1; end
            PH_SIZE:  begin w_byte = {6'd0, r_size}; w_crc_in = 1'b1; end
            PH_ID_CRC, PH_DATA_CRC: w_byte = (r_cnt == 11'd0) ? r_crc[15:8] : r_crc[7:0];
            PH_DAM:   begin w_byte = B_DAM;  w_crc_in = 1'b1; end
            PH_DATA:  begin w_byte = B_FILL; w_crc_in = 1'b1; end
            default:  w_byte = B_GAP;
        endcase
    end

    always_comb begin
        n_busy   = r_busy;
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_off    = r_off;
        n_sidx   = r_sidx;
        n_crc    = r_crc;
        n_cyl    = r_cyl;
        n_head   = r_head;
        n_marks  = r_marks;
        n_status = ST_BYTE;
        n_data   = 8'd0;
        n_offset = 14'd0;
        n_flag   = 1'b0;
        n_slot   = 6'd0;
        n_entry  = 16'd0;
        n_last   = 1'b0;
        if (i_req.is_start) begin
            if (!r_dd || (r_spt > SPT_MAX) || (w_len < LEN_MIN) || (w_len > LEN_MAX)) begin
                n_busy   = 1'b0;
                n_status = ST_REJECTED;
            end else begin
                n_busy   = 1'b1;
                n_phase  = PH_GAP0;
                n_cnt    = 11'd0;
                n_off    = 14'(TABLE_BYTES);
                n_sidx   = 7'd0;
                n_crc    = 16'hffff;
                n_cyl    = i_req.cylinder;
                n_head   = i_req.head_number;
                n_marks  = 7'd0;
                n_status = ST_STARTED;
                n_offset = 14'(TABLE_BYTES);
            end
        end else if (!r_busy) begin
            n_status = ST_IDLE;
            n_offset = r_off;
        end else begin
            n_data   = w_byte;
            n_offset = r_off;
            n_crc    = w_crc_in ? crc_byte(w_crc_base, w_byte) : w_crc_base;
            if (r_phase == PH_ID_AM) begin
                n_flag  = 1'b1;
                n_slot  = r_marks[5:0];
                n_entry = {2'b10, r_off};
                n_marks = r_marks + 7'd1;
            end
            n_off = w_next_off[13:0];
            if (w_next_off >= w_len) begin
                n_last = 1'b1;
                n_busy = 1'b0;
            end else if (r_phase == PH_FILL) begin
                n_cnt = 11'd0;
            end else if (w_cnt_inc >= 12'(w_ph_len)) begin
                n_cnt = 11'd0;
                case (r_phase)
                    PH_GAP0:      n_phase = PH_SYNC0;
                    PH_SYNC0:     n_phase = PH_IAM;
                    PH_IAM:       n_phase = PH_IDXAM;
                    PH_IDXAM:     n_phase = PH_GAP1;
                    PH_GAP1:      n_phase = w_choose;
                    PH_ID_SYNC:   n_phase = PH_ID_A1;
                    PH_ID_A1:     n_phase = PH_ID_AM;
                    PH_ID_AM:     n_phase = PH_CYL;
                    PH_CYL:       n_phase = PH_HEAD;
                    PH_HEAD:      n_phase = PH_SEC;
                    PH_SEC:       n_phase = PH_SIZE;
                    PH_SIZE:      n_phase = PH_ID_CRC;
                    PH_ID_CRC:    n_phase = PH_GAP2;
                    PH_GAP2:      n_phase = PH_DATA_SYNC;
                    PH_DATA_SYNC: n_phase = PH_DATA_A1;
                    PH_DATA_A1:   n_phase = PH_DAM;
                    PH_DAM:       n_phase = PH_DATA;
                    PH_DATA:      n_phase = PH_DATA_CRC;
                    PH_DATA_CRC:  n_phase = PH_GAP3;
                    PH_GAP3: begin
                        n_sidx  = w_sidx_adv;
                        n_phase = w_choose;
                    end
                    default:      n_phase = PH_FILL;
                endcase
            end else begin
                n_cnt = w_cnt_inc[10:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spt     <= 7'd18;
            r_first   <= 8'd1;
            r_size    <= 2'd1;
            r_ilv     <= 1'b0;
            r_tbytes  <= 14'd6400;
            r_dd      <= 1'b1;
            r_busy    <= 1'b0;
            r_phase   <= PH_GAP0;
            r_cnt     <= 11'd0;
            r_off     <= 14'(TABLE_BYTES);
            r_sidx    <= 7'd0;
            r_crc     <= 16'hffff;
            r_cyl     <= 8'd0;
            r_head    <= 1'b0;
            r_marks   <= 7'd0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SPT:    r_spt    <= i_cfg_data[6:0];
                    CFG_FIRST:  r_first  <= i_cfg_data[7:0];
                    CFG_SIZE:   r_size   <= i_cfg_data[1:0];
                    CFG_ILV:    r_ilv    <= i_cfg_data[0];
                    CFG_TBYTES: r_tbytes <= i_cfg_data;
                    CFG_DD:     r_dd     <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (fire) begin
                r_busy  <= n_busy;
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_off   <= n_off;
                r_sidx  <= n_sidx;
                r_crc   <= n_crc;
                r_cyl   <= n_cyl;
                r_head  <= n_head;
                r_marks <= n_marks;
            end
            if (fire) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status <= n_status;
            r_data   <= n_data;
            r_offset <= n_offset;
            r_flag   <= n_flag;
            r_slot   <= n_slot;
            r_entry  <= n_entry;
            r_last   <= n_last;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {1'b0, r_entry, r_slot, r_flag, r_offset, r_data, r_status};
    assign o_m_axis_tlast  = r_last;

endmodule

// ===== rtl/mfm_track_format_generator_core.sv =====
// Each accepted item is written into the two-entry request queue and, when the engine
// takes it, its result is written into the output register.
// Throughput: one item per cycle while the output is not stalled.
// A two-entry request queue decouples intake from the engine's output stall.
// Reset (i_rst_n low, synchronous): configuration to defaults, track idle,
// offset 128, CRC all ones, queue and output empty.
// Top level of the MFM double-density track format generator.
module mfm_track_format_generator_core #(
    parameter int unsigned MARK_SLOTS     = mfmtfg_pkg::MARK_SLOTS_D,
    parameter int unsigned INTERLEAVE_LEN = mfmtfg_pkg::ILV_LEN_D
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mfmtfg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mfmtfg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // cylinder[7:0], head_number[8], zero[15:9]
    input  logic [mfmtfg_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // req_type
    input  logic                                i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // status[1:0], data_byte[9:2], byte_offset[23:10], id_mark_flag[24],
    // id_mark_slot[30:25], id_mark_entry[46:31], zero[47]
    output logic [mfmtfg_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // last_byte
    output logic                                o_m_axis_tlast
);
    import mfmtfg_pkg::*;

    logic req_valid;
    logic req_ready;
    t_req req;

    mfmtfg_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_req_valid     (req_valid),
        .i_req_ready     (req_ready),
        .o_req           (req)
    );

    mfmtfg_engine #(
        .MARK_SLOTS     (MARK_SLOTS),
        .INTERLEAVE_LEN (INTERLEAVE_LEN)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_req_valid     (req_valid),
        .o_req_ready     (req_ready),
        .i_req           (req),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the MFM double-density track format generator core.
`timescale 1ns / 1ps

import mfmtfg_pkg::*;

typedef enum bit {
    REQ_START = 1'b0,
    REQ_NEXT  = 1'b1
} t_req_kind;

class track_scoreboard;

    typedef enum bit [4:0] {
        PH_LEAD_GAP   = 5'd0,
        PH_LEAD_ZERO  = 5'd1,
        PH_INDEX_SYNC = 5'd2,
        PH_INDEX_MARK = 5'd3,
        PH_POST_INDEX = 5'd4,
        PH_ID_ZERO    = 5'd6,
        PH_ID_SYNC    = 5'd7,
        PH_ID_MARK    = 5'd8,
        PH_CYL        = 5'd9,
        PH_HEAD       = 5'd10,
        PH_SECTOR     = 5'd11,
        PH_SIZE       = 5'd12,
        PH_ID_CRC     = 5'd13,
        PH_ID_GAP     = 5'd14,
        PH_DATA_ZERO  = 5'd15,
        PH_DATA_SYNC  = 5'd16,
        PH_DATA_MARK  = 5'd17,
        PH_DATA       = 5'd18,
        PH_DATA_CRC   = 5'd19,
        PH_DATA_GAP   = 5'd20,
        PH_FILL       = 5'd21
    } t_track_phase;

    typedef struct packed {
        t_status     status;
        logic [7:0]  data;
        logic [13:0] offset;
        logic        mark;
        logic [5:0]  slot;
        logic [15:0] entry;
        logic        last;
    } t_track_result;

    bit [6:0]  spt;
    bit [7:0]  first_id;
    bit [1:0]  size_code;
    bit        ilv;
    bit [13:0] tbytes;
    bit        dd;

    bit        busy;
    bit [4:0]  phase;
    bit [10:0] pcount;
    bit [13:0] woff;
    bit [6:0]  sidx;
    bit [15:0] crc;
    bit [7:0]  cyl;
    bit        hd;
    bit [6:0]  marks;

    bit [4:0]  order2[18];
    bit [4:0]  order3[18];

    t_track_result pending_results[$];
    int unsigned   errors;
    int unsigned   checked;

    function new();
        order2 = '{0, 9, 1, 10, 2, 11, 3, 12, 4, 13, 5, 14, 6, 15, 7, 16, 8, 17};
        order3 = '{0, 6, 12, 1, 7, 13, 2, 8, 14, 3, 9, 15, 4, 10, 16, 5, 11, 17};
        spt       = 7'd18;
        first_id  = 8'd1;
        size_code = 2'd1;
        ilv       = 1'b0;
        tbytes    = 14'd6400;
        dd        = 1'b1;
        busy      = 1'b0;
        phase     = PH_LEAD_GAP;
        pcount    = '0;
        woff      = 14'(TABLE_BYTES);
        sidx      = '0;
        crc       = 16'hffff;
        cyl       = '0;
        hd        = 1'b0;
        marks     = '0;
        errors    = 0;
        checked   = 0;
    endfunction

    function void set_register(t_cfg_idx idx, bit [13:0] v);
        case (idx)
            CFG_SPT:    spt = v[6:0];
            CFG_FIRST:  first_id = v[7:0];
            CFG_SIZE:   size_code = v[1:0];
            CFG_ILV:    ilv = v[0];
            CFG_TBYTES: tbytes = v;
            CFG_DD:     dd = v[0];
            default: ;
        endcase
    endfunction

    function int track_len();
        return (int'(tbytes) + 1) & ~1;
    endfunction

    function int sector_len();
        return 128 << size_code;
    endfunction

    function int phase_len(bit [4:0] ph);
        case (ph)
            PH_LEAD_GAP:                return 54;
            PH_LEAD_ZERO:               return 9;
            PH_INDEX_SYNC:              return 3;
            PH_POST_INDEX:              return 32;
            PH_ID_ZERO:                 return 8;
            PH_ID_SYNC, PH_DATA_SYNC:   return 3;
            PH_ID_CRC, PH_DATA_CRC:     return 2;
            PH_ID_GAP:                  return 22;
            PH_DATA_ZERO:               return 12;
            PH_DATA:                    return sector_len();
            PH_DATA_GAP:                return 24;
            default:                    return 1;
        endcase
    endfunction

    function bit [15:0] crc_step(bit [15:0] c, bit [7:0] v);
        c = c ^ {v, 8'h00};
        repeat (8) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        return c;
    endfunction

    function bit [7:0] sector_id();
        bit [7:0] v;
        v = {1'b0, sidx};
        if (sidx < ILV_LEN_D && sidx < ILV_ENTRIES)
            v = {3'd0, ilv ? order3[sidx] : order2[sidx]};
        return v + first_id;
    endfunction

    function bit [4:0] next_sector_or_fill(int next_off);
        if (sidx < spt && marks < MARK_SLOTS_D &&
                next_off + sector_len() + 82 < track_len())
            return PH_ID_ZERO;
        return PH_FILL;
    endfunction

    function t_track_result step_track(t_req_kind kind, bit [7:0] cyl_in, bit hd_in);
        t_track_result r;
        int            len;
        int            next_off;
        bit [13:0]     off;
        bit [4:0]      ph;
        bit [10:0]     cnt;
        bit [7:0]      b;
        bit            crc_in;
        r = '0;
        len = track_len();
        if (kind == REQ_START) begin
            if (!dd || spt > SPT_MAX || len < 130 || len > 10560) begin
                busy = 1'b0;
                r.status = ST_REJECTED;
                return r;
            end
            busy   = 1'b1;
            phase  = PH_LEAD_GAP;
            pcount = '0;
            woff   = 14'(TABLE_BYTES);
            sidx   = '0;
            crc    = 16'hffff;
            cyl    = cyl_in;
            hd     = hd_in;
            marks  = '0;
            r.status = ST_STARTED;
            r.offset = 14'(TABLE_BYTES);
            return r;
        end
        if (!busy) begin
            r.status = ST_IDLE;
            r.offset = woff;
            return r;
        end
        off    = woff;
        ph     = phase;
        cnt    = pcount;
        b      = B_GAP;
        crc_in = 1'b0;
        case (ph)
            PH_LEAD_ZERO, PH_ID_ZERO, PH_DATA_ZERO: b = B_ZERO;
            PH_INDEX_SYNC: b = B_IAM;
            PH_INDEX_MARK: b = B_IDXAM;
            PH_ID_SYNC, PH_DATA_SYNC: begin
                if (cnt == 0)
                    crc = 16'hffff;
                b = B_SYNC;
                crc_in = 1'b1;
            end
            PH_ID_MARK: begin
                b = B_IDAM;
                crc_in = 1'b1;
                r.mark  = 1'b1;
                r.slot  = marks[5:0];
                r.entry = {2'b10, off};
                marks = marks + 7'd1;
            end
            PH_CYL: begin
                b = cyl;
                crc_in = 1'b1;
            end
            PH_HEAD: begin
                b = {7'd0, hd};
                crc_in = 1'b1;
            end
            PH_SECTOR: begin
                b = sector_id();
                crc_in = 1'b1;
            end
            PH_SIZE: begin
                b = {6'd0, size_code};
                crc_in = 1'b1;
            end
            PH_ID_CRC, PH_DATA_CRC: b = (cnt == 0) ? crc[15:8] : crc[7:0];
            PH_DATA_MARK: begin
                b = B_DAM;
                crc_in = 1'b1;
            end
            PH_DATA: begin
                b = B_FILL;
                crc_in = 1'b1;
            end
            default: b = B_GAP;
        endcase
        if (crc_in)
            crc = crc_step(crc, b);
        r.status = ST_BYTE;
        r.data   = b;
        r.offset = off;
        next_off = int'(off) + 1;
        woff = next_off[13:0];
        if (next_off >= len) begin
            r.last = 1'b1;
            busy = 1'b0;
            return r;
        end
        if (ph >= PH_FILL) begin
            phase  = PH_FILL;
            pcount = '0;
        end else if (int'(cnt) + 1 >= phase_len(ph)) begin
            pcount = '0;
            if (ph == PH_POST_INDEX) begin
                phase = next_sector_or_fill(next_off);
            end else if (ph == PH_DATA_GAP) begin
                sidx  = sidx + 7'd1;
                phase = next_sector_or_fill(next_off);
            end else begin
                phase = ph + 5'd1;
            end
        end else begin
            pcount = cnt + 11'd1;
        end
        return r;
    endfunction

    function void note_request(t_req_kind kind, bit [7:0] cyl_in, bit hd_in);
        pending_results.push_back(step_track(kind, cyl_in, hd_in));
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
        if (errors < 40)
            $display("[%0t] result %0d: %s got %0h expected %0h", $time, checked, what, got,
                     want);
        errors++;
    endtask

    task check_result(logic [47:0] d, logic last);
        t_track_result e;
        if (pending_results.size() == 0) begin
            report("result with nothing outstanding", d[15:0], 16'h0);
            return;
        end
        e = pending_results.pop_front();
        if (d[1:0] !== e.status)   report("status", d[1:0], e.status);
        if (d[9:2] !== e.data)     report("data_byte", d[9:2], e.data);
        if (d[23:10] !== e.offset) report("byte_offset", d[23:10], e.offset);
        if (d[24] !== e.mark)      report("id_mark_flag", d[24], e.mark);
        if (d[30:25] !== e.slot)   report("id_mark_slot", d[30:25], e.slot);
        if (d[46:31] !== e.entry)  report("id_mark_entry", d[46:31], e.entry);
        if (last !== e.last)       report("last_byte", last, e.last);
        checked++;
    endtask

endclass

module tb;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_TRACK  = 700;
    localparam int ITEM_GOAL   = 1050;
    localparam int ITEM_CAP    = 1100;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_DATA_W-1:0]   i_s_axis_tdata = '0;
    logic                   i_s_axis_tuser = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  o_m_axis_tdata;
    logic                   o_m_axis_tlast;

    track_scoreboard sb = new();
    bit              quiet = 1'b0;
    bit              hold_request = 1'b0;
    int unsigned     sent_count = 0;
    int unsigned     cycle_count = 0;

    mfm_track_format_generator_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic send_item(t_req_kind kind, bit [7:0] cyl, bit hd);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= {7'd0, hd, cyl};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_request(kind, cyl, hd);
        sent_count++;
    endtask

    task automatic send_random(t_req_kind kind);
        send_item(kind, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(t_cfg_idx idx, bit [13:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        sb.set_register(idx, v);
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_session();
        int unsigned pick;
        int          remaining;
        int          n;
        bit [1:0]    sz;
        bit [13:0]   len_v;
        bit [6:0]    spt_v;
        quiet = ($urandom_range(0, 3) == 0);
        settle();
        pick = $urandom_range(0, 19);
        sz = (pick < 12) ? 2'd0 : (pick < 16) ? 2'd1 : (pick < 19) ? 2'd2 : 2'd3;
        if ($urandom_range(0, 11) == 0) begin
            case ($urandom_range(0, 9))
                0: len_v = 14'd0;
                1: len_v = 14'd127;
                2: len_v = 14'd128;
                3: len_v = 14'd129;
                4: len_v = 14'd130;
                5: len_v = 14'd131;
                6: len_v = 14'd10559;
                7: len_v = 14'd10560;
                8: len_v = 14'd10561;
                default: len_v = 14'd16383;
            endcase
        end else begin
            len_v = 14'($urandom_range(130, 312 + (128 << sz) + ((sz == 0) ? 500 : 150)));
        end
        case ($urandom_range(0, 9))
            0: spt_v = 7'd0;
            1: spt_v = 7'd64;
            2: spt_v = 7'($urandom_range(65, 127));
            default: spt_v = 7'($urandom_range(1, 6));
        endcase
        if ($urandom_range(0, 2) != 0) write_reg(CFG_SPT, 14'(spt_v));
        if ($urandom_range(0, 2) != 0) write_reg(CFG_FIRST, 14'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) != 0) write_reg(CFG_SIZE, 14'(sz));
        if ($urandom_range(0, 2) != 0) write_reg(CFG_ILV, 14'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) != 0) write_reg(CFG_TBYTES, len_v);
        if ($urandom_range(0, 2) != 0) write_reg(CFG_DD, 14'($urandom_range(0, 14) != 0));
        end_writes();
        if ($urandom_range(0, 7) != 0)
            send_random(REQ_START);
        remaining = sb.track_len() - int'(sb.woff);
        if (!sb.busy || remaining <= 0)
            n = $urandom_range(1, 4);
        else
            n = remaining + $urandom_range(0, 3);
        if (sb.track_len() > 3000 && n > 150)
            n = 150;
        if (n > ITEM_CAP - int'(sent_count))
            n = ITEM_CAP - int'(sent_count);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 59) == 0)
                send_random(REQ_START);
            else
                send_random(REQ_NEXT);
        end
    endtask

    initial begin : receiver
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_m_axis_tready && o_m_axis_tvalid) begin
                sb.check_result(o_m_axis_tdata, o_m_axis_tlast);
                stall_left = quiet ? 0 : $urandom_range(0, 13);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = 200;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: next while idle, start, restart while busy
        send_item(REQ_NEXT, 8'h5a, 1'b1);
        send_item(REQ_START, 8'hff, 1'b1);
        repeat (3) send_item(REQ_NEXT, 8'h00, 1'b0);
        send_item(REQ_START, 8'h00, 1'b0);
        send_item(REQ_NEXT, 8'hff, 1'b1);

        settle();
        write_reg(CFG_DD, 14'd0);
        end_writes();
        send_item(REQ_START, 8'h12, 1'b1);
        send_item(REQ_NEXT, 8'h34, 1'b0);

        settle();
        write_reg(CFG_DD, 14'd1);
        write_reg(CFG_SPT, 14'd65);
        end_writes();
        send_item(REQ_START, 8'h56, 1'b0);

        // odd length rounds up to the shortest track, cut inside the index gap
        settle();
        write_reg(CFG_SPT, 14'd64);
        write_reg(CFG_TBYTES, 14'd129);
        end_writes();
        send_item(REQ_START, 8'h81, 1'b1);
        repeat (3) send_item(REQ_NEXT, 8'h7e, 1'b0);

        settle();
        write_reg(CFG_TBYTES, 14'd128);
        end_writes();
        send_item(REQ_START, 8'h01, 1'b0);

        settle();
        write_reg(CFG_TBYTES, 14'd10561);
        end_writes();
        send_item(REQ_START, 8'h02, 1'b1);

        settle();
        write_reg(CFG_TBYTES, 14'd10560);
        write_reg(CFG_SIZE, 14'd3);
        write_reg(CFG_FIRST, 14'd255);
        write_reg(CFG_ILV, 14'd1);
        write_reg(CFG_SPT, 14'd0);
        end_writes();
        send_item(REQ_START, 8'ha5, 1'b0);
        repeat (3) send_item(REQ_NEXT, 8'h5a, 1'b1);

        // full track: two sectors, then fill up to the end
        settle();
        write_reg(CFG_SPT, 14'd2);
        write_reg(CFG_SIZE, 14'd0);
        write_reg(CFG_TBYTES, 14'(LONG_TRACK));
        write_reg(CFG_FIRST, 14'($urandom_range(0, 255)));
        write_reg(CFG_ILV, 14'($urandom_range(0, 1)));
        end_writes();
        send_random(REQ_START);
        for (int i = 0; i < LONG_TRACK - int'(TABLE_BYTES) + 2; i++) begin
            if (i == 100)
                hold_request = 1'b1;
            send_random(REQ_NEXT);
        end

        while (sent_count < ITEM_GOAL)
            run_session();

        quiet = 1'b0;
        settle();
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== mfm_track_format_generator_core.f =====
rtl/mfmtfg_pkg.sv
rtl/mfmtfg_front.sv
rtl/mfmtfg_engine.sv
rtl/mfm_track_format_generator_core.sv
tb/tb.sv
